FILE: hw/rtl/ubtm_pkg.sv
package ubtm_pkg;

    localparam int PACKET_MAX_DEF  = 256;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [2:0] OP_START_UP   = 3'd0;
    localparam logic [2:0] OP_START_DOWN = 3'd1;
    localparam logic [2:0] OP_START_QRY  = 3'd2;
    localparam logic [2:0] OP_PAYLOAD    = 3'd3;
    localparam logic [2:0] OP_LINK       = 3'd4;

    localparam logic [1:0] KIND_TX     = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;
    localparam logic [1:0] KIND_QUERY  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_REJECT   = 2'd1;
    localparam logic [1:0] ST_MISMATCH = 2'd2;

    localparam logic [7:0]  CMD_UP     = 8'h02;
    localparam logic [7:0]  CMD_DOWN   = 8'h01;
    localparam logic [7:0]  CMD_QUERY  = 8'h05;
    localparam logic [7:0]  CHK_SEED   = 8'hAA;
    localparam logic [31:0] QUERY_FAIL = 32'hFFFF_FFFF;
    localparam logic [24:0] MAX_LEN    = 25'h100_0000;

    typedef struct packed {
        logic [2:0]  op;
        logic [24:0] total_length;
        logic [7:0]  byte_in;
    } t_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  byte_out;
        logic [23:0] data_address;
        logic [1:0]  status;
        logic [31:0] query_value;
        logic        last;
    } t_out;

    // A header job carries the command in res.byte_out and the packet address in
    // res.data_address; the back part expands it into six transfers.
    typedef struct packed {
        logic       is_hdr;
        t_out       res;
        logic [7:0] hdr_len;
        logic [7:0] hdr_chk;
    } t_job;

endpackage

FILE: hw/rtl/ubtm_front.sv
module ubtm_front #(
    parameter int PACKET_MAX = ubtm_pkg::PACKET_MAX_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  ubtm_pkg::t_in  i_in_data,
    output logic           o_push,
    output ubtm_pkg::t_job o_job,
    input  logic           i_q_full
);

    localparam logic [1:0] M_IDLE  = 2'd0;
    localparam logic [1:0] M_UP    = 2'd1;
    localparam logic [1:0] M_DOWN  = 2'd2;
    localparam logic [1:0] M_QUERY = 2'd3;

    localparam logic [2:0] P_IDLE = 3'd0;
    localparam logic [2:0] P_ACK  = 3'd1;
    localparam logic [2:0] P_PAY  = 3'd2;
    localparam logic [2:0] P_CHK  = 3'd3;
    localparam logic [2:0] P_QRX  = 3'd4;

    logic [1:0]  r_mode, n_mode;
    logic [2:0]  r_phase, n_phase;
    logic [23:0] r_cur_addr, n_cur_addr;
    logic [24:0] r_rem, n_rem;
    logic [8:0]  r_left, n_left;
    logic [8:0]  r_plen, n_plen;
    logic [7:0]  r_chk, n_chk;
    logic [7:0]  r_hdr_chk, n_hdr_chk;
    logic [31:0] r_qshift, n_qshift;
    logic [2:0]  r_qcnt, n_qcnt;

    logic        w_acc;
    logic [24:0] w_len_sat;
    logic [24:0] w_rem_after;
    logic        w_start;
    logic [23:0] w_h_addr;
    logic [24:0] w_h_rem;
    logic [8:0]  w_h_plen;
    logic [7:0]  w_h_chk;
    logic [8:0]  w_left_dec;
    logic        w_xfer;
    logic [7:0]  w_b;

    assign o_in_ready = !i_q_full;
    assign w_acc      = i_in_valid && !i_q_full;
    assign w_b        = i_in_data.byte_in;
    assign w_xfer     = (r_mode == M_UP) || (r_mode == M_DOWN);
    assign w_left_dec = r_left - 9'd1;

    assign w_len_sat   = (i_in_data.total_length > ubtm_pkg::MAX_LEN)
                       ? ubtm_pkg::MAX_LEN : i_in_data.total_length;
    assign w_rem_after = (r_rem >= 25'(r_plen)) ? (r_rem - 25'(r_plen)) : 25'd0;

    assign w_start  = (i_in_data.op == ubtm_pkg::OP_START_UP)
                   || (i_in_data.op == ubtm_pkg::OP_START_DOWN);
    assign w_h_addr = w_start ? 24'd0 : r_cur_addr;
    assign w_h_rem  = w_start ? w_len_sat : w_rem_after;
    assign w_h_plen = (w_h_rem >= 25'(PACKET_MAX)) ? 9'(PACKET_MAX) : w_h_rem[8:0];
    assign w_h_chk  = ubtm_pkg::CHK_SEED ^ w_h_addr[7:0] ^ w_h_addr[15:8]
                    ^ w_h_addr[23:16] ^ w_h_plen[7:0];

    always_comb begin
        n_mode     = r_mode;
        n_phase    = r_phase;
        n_cur_addr = r_cur_addr;
        n_rem      = r_rem;
        n_left     = r_left;
        n_plen     = r_plen;
        n_chk      = r_chk;
        n_hdr_chk  = r_hdr_chk;
        n_qshift   = r_qshift;
        n_qcnt     = r_qcnt;
        o_push     = 1'b0;
        o_job      = '0;
        o_job.res.last = 1'b1;
        if (w_acc) begin
            case (i_in_data.op)
                ubtm_pkg::OP_START_UP, ubtm_pkg::OP_START_DOWN: begin
                    n_mode  = M_IDLE;
                    n_phase = P_IDLE;
                    o_push  = 1'b1;
                    if (w_len_sat == 25'd0) begin
                        o_job.res.kind   = ubtm_pkg::KIND_STATUS;
                        o_job.res.status = ubtm_pkg::ST_OK;
                    end else begin
                        n_mode     = (i_in_data.op == ubtm_pkg::OP_START_UP) ? M_UP : M_DOWN;
                        n_phase    = P_ACK;
                        n_cur_addr = 24'd0;
                        n_rem      = w_len_sat;
                        n_plen     = w_h_plen;
                        n_hdr_chk  = w_h_chk;
                        o_job.is_hdr       = 1'b1;
                        o_job.res.kind     = ubtm_pkg::KIND_TX;
                        o_job.res.byte_out = (i_in_data.op == ubtm_pkg::OP_START_UP)
                                           ? ubtm_pkg::CMD_UP : ubtm_pkg::CMD_DOWN;
                        o_job.res.data_address = w_h_addr;
                        o_job.hdr_len      = w_h_plen[7:0];
                        o_job.hdr_chk      = w_h_chk;
                    end
                end
                ubtm_pkg::OP_START_QRY: begin
                    n_mode   = M_QUERY;
                    n_phase  = P_QRX;
                    n_qshift = 32'd0;
                    n_qcnt   = 3'd0;
                    n_chk    = ubtm_pkg::CHK_SEED;
                    o_push   = 1'b1;
                    o_job.res.kind     = ubtm_pkg::KIND_TX;
                    o_job.res.byte_out = ubtm_pkg::CMD_QUERY;
                end
                ubtm_pkg::OP_PAYLOAD: begin
                    if (r_mode == M_UP && r_phase == P_PAY) begin
                        n_chk      = r_chk ^ w_b;
                        n_left     = w_left_dec;
                        n_cur_addr = r_cur_addr + 24'd1;
                        if (w_left_dec == 9'd0) begin
                            n_phase = P_CHK;
                        end
                        o_push = 1'b1;
                        o_job.res.kind     = ubtm_pkg::KIND_TX;
                        o_job.res.byte_out = w_b;
                    end
                end
                ubtm_pkg::OP_LINK: begin
                    if (r_phase == P_ACK && w_xfer) begin
                        if (w_b != 8'd0) begin
                            n_mode  = M_IDLE;
                            n_phase = P_IDLE;
                            o_push  = 1'b1;
                            o_job.res.kind   = ubtm_pkg::KIND_STATUS;
                            o_job.res.status = ubtm_pkg::ST_REJECT;
                        end else begin
                            n_chk   = r_hdr_chk;
                            n_left  = r_plen;
                            n_phase = (r_plen == 9'd0) ? P_CHK : P_PAY;
                        end
                    end else if (r_phase == P_PAY && r_mode == M_DOWN) begin
                        n_chk      = r_chk ^ w_b;
                        n_left     = w_left_dec;
                        n_cur_addr = r_cur_addr + 24'd1;
                        if (w_left_dec == 9'd0) begin
                            n_phase = P_CHK;
                        end
                        o_push = 1'b1;
                        o_job.res.kind         = ubtm_pkg::KIND_DATA;
                        o_job.res.byte_out     = w_b;
                        o_job.res.data_address = r_cur_addr;
                    end else if (r_phase == P_CHK && w_xfer) begin
                        o_push = 1'b1;
                        if (w_b != r_chk) begin
                            n_mode  = M_IDLE;
                            n_phase = P_IDLE;
                            o_job.res.kind   = ubtm_pkg::KIND_STATUS;
                            o_job.res.status = ubtm_pkg::ST_MISMATCH;
                        end else begin
                            n_rem = w_rem_after;
                            if (w_rem_after == 25'd0) begin
                                n_mode  = M_IDLE;
                                n_phase = P_IDLE;
                                o_job.res.kind   = ubtm_pkg::KIND_STATUS;
                                o_job.res.status = ubtm_pkg::ST_OK;
                            end else begin
                                n_phase   = P_ACK;
                                n_plen    = w_h_plen;
                                n_hdr_chk = w_h_chk;
                                o_job.is_hdr       = 1'b1;
                                o_job.res.kind     = ubtm_pkg::KIND_TX;
                                o_job.res.byte_out = (r_mode == M_UP)
                                                   ? ubtm_pkg::CMD_UP : ubtm_pkg::CMD_DOWN;
                                o_job.res.data_address = w_h_addr;
                                o_job.hdr_len      = w_h_plen[7:0];
                                o_job.hdr_chk      = w_h_chk;
                            end
                        end
                    end else if (r_phase == P_QRX && r_mode == M_QUERY) begin
                        if (!r_qcnt[2]) begin
                            case (r_qcnt[1:0])
                                2'd0:    n_qshift[7:0]   = r_qshift[7:0]   | w_b;
                                2'd1:    n_qshift[15:8]  = r_qshift[15:8]  | w_b;
                                2'd2:    n_qshift[23:16] = r_qshift[23:16] | w_b;
                                default: n_qshift[31:24] = r_qshift[31:24] | w_b;
                            endcase
                            n_chk  = r_chk ^ w_b;
                            n_qcnt = r_qcnt + 3'd1;
                        end else begin
                            n_mode  = M_IDLE;
                            n_phase = P_IDLE;
                            n_qcnt  = 3'd0;
                            o_push  = 1'b1;
                            o_job.res.kind        = ubtm_pkg::KIND_QUERY;
                            o_job.res.query_value = (w_b == r_chk) ? r_qshift
                                                                   : ubtm_pkg::QUERY_FAIL;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= M_IDLE;
            r_phase    <= P_IDLE;
            r_cur_addr <= 24'd0;
            r_rem      <= 25'd0;
            r_left     <= 9'd0;
            r_plen     <= 9'd0;
            r_chk      <= 8'd0;
            r_hdr_chk  <= 8'd0;
            r_qshift   <= 32'd0;
            r_qcnt     <= 3'd0;
        end else begin
            r_mode     <= n_mode;
            r_phase    <= n_phase;
            r_cur_addr <= n_cur_addr;
            r_rem      <= n_rem;
            r_left     <= n_left;
            r_plen     <= n_plen;
            r_chk      <= n_chk;
            r_hdr_chk  <= n_hdr_chk;
            r_qshift   <= n_qshift;
            r_qcnt     <= n_qcnt;
        end
    end

endmodule

FILE: hw/rtl/ubtm_queue.sv
module ubtm_queue #(
    parameter int QUEUE_DEPTH = ubtm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ubtm_pkg::t_job i_job,
    output logic           o_full,
    output logic           o_valid,
    output ubtm_pkg::t_job o_job,
    input  logic           i_pop
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    ubtm_pkg::t_job r_mem [QUEUE_DEPTH];
    logic [AW-1:0]  r_wr, n_wr;
    logic [AW-1:0]  r_rd, n_rd;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           w_wr_en;
    logic           w_rd_en;

    assign o_full  = (r_cnt == CW'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign w_wr_en = i_push && !o_full;
    assign w_rd_en = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_wr_en) begin
            n_wr = (r_wr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (w_rd_en) begin
            n_rd = (r_rd == AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        if (w_wr_en && !w_rd_en) begin
            n_cnt = r_cnt + CW'(1);
        end else if (!w_wr_en && w_rd_en) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

FILE: hw/rtl/ubtm_back.sv
module ubtm_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  ubtm_pkg::t_job i_q_job,
    output logic           o_q_pop,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output ubtm_pkg::t_out o_out_data
);

    localparam logic [2:0] H_CMD   = 3'd0;
    localparam logic [2:0] H_ADDR0 = 3'd1;
    localparam logic [2:0] H_ADDR1 = 3'd2;
    localparam logic [2:0] H_ADDR2 = 3'd3;
    localparam logic [2:0] H_LEN   = 3'd4;
    localparam logic [2:0] H_CHK   = 3'd5;

    ubtm_pkg::t_job r_job, n_job;
    logic           r_jv, n_jv;
    logic [2:0]     r_idx, n_idx;
    ubtm_pkg::t_out r_out, n_out;
    logic           r_ov, n_ov;

    ubtm_pkg::t_out w_gen;
    logic           w_adv;
    logic           w_job_end;

    assign w_adv     = !r_ov || i_out_ready;
    assign w_job_end = !r_job.is_hdr || (r_idx == H_CHK);
    assign o_q_pop   = i_q_valid && (!r_jv || (w_adv && w_job_end));

    always_comb begin
        w_gen = r_job.res;
        if (r_job.is_hdr) begin
            w_gen              = '0;
            w_gen.kind         = ubtm_pkg::KIND_TX;
            w_gen.last         = (r_idx == H_CHK);
            case (r_idx)
                H_CMD:   w_gen.byte_out = r_job.res.byte_out;
                H_ADDR0: w_gen.byte_out = r_job.res.data_address[7:0];
                H_ADDR1: w_gen.byte_out = r_job.res.data_address[15:8];
                H_ADDR2: w_gen.byte_out = r_job.res.data_address[23:16];
                H_LEN:   w_gen.byte_out = r_job.hdr_len;
                default: w_gen.byte_out = r_job.hdr_chk;
            endcase
        end
    end

    always_comb begin
        n_job = r_job;
        n_jv  = r_jv;
        n_idx = r_idx;
        n_out = r_out;
        n_ov  = r_ov;
        if (w_adv) begin
            n_ov = r_jv;
            if (r_jv) begin
                n_out = w_gen;
                n_idx = r_idx + 3'd1;
                if (w_job_end) begin
                    n_jv = 1'b0;
                end
            end
        end
        if (o_q_pop) begin
            n_job = i_q_job;
            n_jv  = 1'b1;
            n_idx = H_CMD;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        r_out <= n_out;
        if (!i_rst_n) begin
            r_jv  <= 1'b0;
            r_idx <= H_CMD;
            r_ov  <= 1'b0;
        end else begin
            r_jv  <= n_jv;
            r_idx <= n_idx;
            r_ov  <= n_ov;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

endmodule

FILE: hw/rtl/uart_block_transfer_master_core.sv
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_ready    i_in_data  (ubtm_pkg::t_in)
// output    out        o_out_valid / i_out_ready  o_out_data (ubtm_pkg::t_out)
//
// The front part takes one item per cycle while the job queue has room.
// A single result passes through the job queue and the back part's job register to
// the output register. Unless the output stalls, a packet header is six transfers
// from the back part at one per cycle, and byte items run back to back likewise.
// Reset is synchronous and active low; it empties the queue and the output register.
// A stalled output fills the queue, and the input then stalls in turn.
module uart_block_transfer_master_core #(
    parameter int PACKET_MAX  = ubtm_pkg::PACKET_MAX_DEF,
    parameter int QUEUE_DEPTH = ubtm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  ubtm_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output ubtm_pkg::t_out o_out_data
);

    logic           w_push;
    ubtm_pkg::t_job w_push_job;
    logic           w_q_full;
    logic           w_q_valid;
    ubtm_pkg::t_job w_q_job;
    logic           w_q_pop;

    ubtm_front #(
        .PACKET_MAX (PACKET_MAX)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_push     (w_push),
        .o_job      (w_push_job),
        .i_q_full   (w_q_full)
    );

    ubtm_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_job   (w_q_job),
        .i_pop   (w_q_pop)
    );

    ubtm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_job     (w_q_job),
        .o_q_pop     (w_q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_full)
        else $error("A job was pushed into a full queue.");

    a_single_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.kind != ubtm_pkg::KIND_TX) |-> o_out_data.last)
        else $error("A status, query or data transfer was not marked last.");

    a_idle_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> (!o_out_valid && !w_q_valid))
        else $error("Output or queue not empty after reset.");

endmodule
